>>> sv/ffdm_pkg.sv
// Shared types, constants and modular helpers for the Fibonacci modulo block.
package ffdm_pkg;

    localparam int INDEX_BITS = 32;
    localparam int WORD_BITS  = 32;
    localparam int BIT_CW     = $clog2(INDEX_BITS + 1);
    localparam int STEP_CW    = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        MUL_EVEN = 2'd0,
        MUL_SQ0  = 2'd1,
        MUL_SQ1  = 2'd2
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        logic     mul_step;
        logic     mul_store;
        t_mul_sel mul_sel;
        t_mul_sel store_sel;
        logic     comb;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic trivial_mod;
    } t_sts;

    // (a + b) mod m for a, b < m
    function automatic t_word mod_add(input t_word a, input t_word b, input t_word m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    // (a - b) mod m for a, b < m
    function automatic t_word mod_sub(input t_word a, input t_word b, input t_word m);
        t_word r;
        if (a >= b) begin
            r = a - b;
        end else begin
            r = a + (m - b);
        end
        return r;
    endfunction

endpackage

>>> sv/ffdm_datapath.sv
// Datapath: shared bit-serial modular multiplier, one operand bit per step.
module ffdm_datapath (
    input  logic            i_clk,
    input  logic            i_start,
    input  logic            i_step,
    input  ffdm_pkg::t_word i_x,
    input  ffdm_pkg::t_word i_y,
    input  ffdm_pkg::t_word i_m,
    output ffdm_pkg::t_word o_prod
);

    ffdm_pkg::t_word r_acc, r_x, r_y;
    ffdm_pkg::t_word acc_dbl, acc_step;

    always_comb begin
        // double and add, most significant bit of y first
        acc_dbl  = ffdm_pkg::mod_add(r_acc, r_acc, i_m);
        acc_step = r_y[ffdm_pkg::WORD_BITS-1] ? ffdm_pkg::mod_add(acc_dbl, r_x, i_m) : acc_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (i_step) begin
            r_acc <= acc_step;
            r_y   <= {r_y[ffdm_pkg::WORD_BITS-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;

endmodule

>>> sv/ffdm_dp.sv
// Datapath: Fibonacci pair, bit-serial modular multiplier and result registers.
module ffdm_dp (
    input  logic                             i_clk,
    input  ffdm_pkg::t_cmd                   i_cmd,
    input  logic [ffdm_pkg::WORD_BITS-1:0]   i_index_n,
    input  logic [ffdm_pkg::WORD_BITS-1:0]   i_modulus,
    output ffdm_pkg::t_sts                   o_sts,
    output logic [ffdm_pkg::WORD_BITS-1:0]   o_fib_mod,
    output logic [ffdm_pkg::WORD_BITS-1:0]   o_doubled_fib_mod
);

    logic [ffdm_pkg::INDEX_BITS-1:0] r_n;
    ffdm_pkg::t_word r_m, r_fk, r_fk1;
    ffdm_pkg::t_word r_even, r_sq0, r_sq1;
    ffdm_pkg::t_word r_fib, r_dbl;
    ffdm_pkg::t_word t_diff, odd, sum_eo;
    ffdm_pkg::t_word mul_x, mul_y, mul_prod;

    always_comb begin
        // 2*F(k+1) - F(k)
        t_diff   = ffdm_pkg::mod_sub(ffdm_pkg::mod_add(r_fk1, r_fk1, r_m), r_fk, r_m);
        odd      = ffdm_pkg::mod_add(r_sq0, r_sq1, r_m);
        sum_eo   = ffdm_pkg::mod_add(r_even, odd, r_m);
        case (i_cmd.mul_sel)
            ffdm_pkg::MUL_EVEN: begin
                mul_x = r_fk;
                mul_y = t_diff;
            end
            ffdm_pkg::MUL_SQ0: begin
                mul_x = r_fk;
                mul_y = r_fk;
            end
            default: begin
                mul_x = r_fk1;
                mul_y = r_fk1;
            end
        endcase
    end

    ffdm_datapath u_mul (
        .i_clk   (i_clk),
        .i_start (i_cmd.mul_start),
        .i_step  (i_cmd.mul_step),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_m     (r_m),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= ffdm_pkg::INDEX_BITS'(i_index_n);
            r_m   <= i_modulus;
            r_fk  <= '0;
            r_fk1 <= ffdm_pkg::t_word'(1);
        end
        if (i_cmd.mul_store) begin
            case (i_cmd.store_sel)
                ffdm_pkg::MUL_EVEN: r_even <= mul_prod;
                ffdm_pkg::MUL_SQ0:  r_sq0  <= mul_prod;
                default:            r_sq1  <= mul_prod;
            endcase
        end
        if (i_cmd.comb) begin
            if (r_n[ffdm_pkg::INDEX_BITS-1]) begin
                r_fk  <= odd;
                r_fk1 <= sum_eo;
            end else begin
                r_fk  <= r_even;
                r_fk1 <= odd;
            end
            r_n <= {r_n[ffdm_pkg::INDEX_BITS-2:0], 1'b0};
        end
        if (i_cmd.fin) begin
            r_fib <= r_fk;
            r_dbl <= ffdm_pkg::mod_add(r_fk, r_fk, r_m);
        end
    end

    assign o_sts.trivial_mod = (r_m <= ffdm_pkg::t_word'(1));
    assign o_fib_mod         = r_fib;
    assign o_doubled_fib_mod = r_dbl;

endmodule

>>> sv/ffdm_ctrl.sv
// Controller: sequences bit steps and multiplies, owns both handshakes.
module ffdm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ffdm_pkg::t_sts i_sts,
    output ffdm_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_NEXT,
        S_COMB,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic [ffdm_pkg::BIT_CW-1:0]  r_bit, n_bit;
    logic [ffdm_pkg::STEP_CW-1:0] r_step, n_step;
    ffdm_pkg::t_mul_sel           r_sel, n_sel;
    logic                         r_out_valid, n_out_valid;
    logic                         out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_step      = r_step;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel   = r_sel;
        o_cmd.store_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit      = ffdm_pkg::BIT_CW'(ffdm_pkg::INDEX_BITS);
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                if (i_sts.trivial_mod) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = ffdm_pkg::MUL_EVEN;
                    n_sel           = ffdm_pkg::MUL_EVEN;
                    n_step          = ffdm_pkg::STEP_CW'(ffdm_pkg::WORD_BITS - 1);
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_NEXT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_NEXT: begin
                // store the finished product and start the next one in the same cycle
                o_cmd.mul_store = 1'b1;
                if (r_sel == ffdm_pkg::MUL_SQ1) begin
                    n_state = S_COMB;
                end else begin
                    n_sel   = (r_sel == ffdm_pkg::MUL_EVEN) ? ffdm_pkg::MUL_SQ0
                                                            : ffdm_pkg::MUL_SQ1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = n_sel;
                    n_step  = ffdm_pkg::STEP_CW'(ffdm_pkg::WORD_BITS - 1);
                    n_state = S_MUL;
                end
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_bit      = r_bit - 1'b1;
                n_state    = (r_bit == ffdm_pkg::BIT_CW'(1)) ? S_FIN : S_PREP;
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_step      <= '0;
            r_sel       <= ffdm_pkg::MUL_EVEN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_step      <= n_step;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_mul_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_step == '0) |=> (r_state == S_NEXT))
        else $error("multiply did not end after its last step");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PREP && r_bit != '0))
        else $error("accepted request did not start the bit walk");

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> o_out_valid)
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_cmd.fin)
        else $error("result overwritten while still pending");

endmodule

>>> sv/fibonacci_fast_doubling_mod_top.sv
// Top level of the Fibonacci modulo block: controller and datapath.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   request  | i_in_valid / o_in_ready    | i_index_n, i_modulus
//   result   | o_out_valid / i_out_ready  | o_fib_mod, o_doubled_fib_mod
//
// Each index bit of a request runs three bit-serial modular multiplies on one shared
// unit, plus setup, store and combine steps.
// A modulus of 0 or 1 skips the bit walk and yields zeros.
// A request is taken only when idle; a finished result waits in the output
// register, and the next request is taken while it waits.
// Reset is synchronous, active low, and clears only control state.
module fibonacci_fast_doubling_mod_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ffdm_pkg::WORD_BITS-1:0] i_index_n,
    input  logic [ffdm_pkg::WORD_BITS-1:0] i_modulus,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ffdm_pkg::WORD_BITS-1:0] o_fib_mod,
    output logic [ffdm_pkg::WORD_BITS-1:0] o_doubled_fib_mod
);

    ffdm_pkg::t_cmd cmd;
    ffdm_pkg::t_sts sts;

    ffdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffdm_dp u_dp (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .i_index_n         (i_index_n),
        .i_modulus         (i_modulus),
        .o_sts             (sts),
        .o_fib_mod         (o_fib_mod),
        .o_doubled_fib_mod (o_doubled_fib_mod)
    );

endmodule

>>> tb/ffdm_checker.sv
// Checker for the Fibonacci modulo block: watches both channels, predicts and compares.
module ffdm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_index_n,
    input  logic [31:0] i_modulus,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_fib_mod,
    input  logic [31:0] i_doubled_fib_mod,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] fib;
        logic [31:0] dbl;
    } t_fib_pair;

    t_fib_pair fib_queue[$];
    int        errors = 0;
    int        r_pending = 0;

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] p;
        p = (a * b) % m;
        return p;
    endfunction

    function automatic t_fib_pair fib_of(logic [31:0] n, logic [31:0] m32);
        logic [63:0] m, fk, fk1, ev, od, t, d;
        t_fib_pair r;
        m = {32'd0, m32};
        if (m == '0) begin
            r.fib = '0;
            r.dbl = '0;
            return r;
        end
        fk = '0;
        fk1 = 64'd1 % m;
        for (int i = ffdm_pkg::INDEX_BITS - 1; i >= 0; i--) begin
            t = ((fk1 + fk1) % m + m - fk) % m;
            ev = mulmod(fk, t, m);
            od = (mulmod(fk, fk, m) + mulmod(fk1, fk1, m)) % m;
            if (i < 32 && n[i]) begin
                fk = od;
                fk1 = (ev + od) % m;
            end else begin
                fk = ev;
                fk1 = od;
            end
        end
        d = (fk + fk) % m;
        r.fib = fk[31:0];
        r.dbl = d[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    assign o_errors  = errors;
    assign o_pending = r_pending;

    always @(posedge i_clk) begin
        t_fib_pair exp_r;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) fib_queue = {fib_queue, fib_of(i_index_n, i_modulus)};
            if (i_out_valid && i_out_ready) begin
                if (fib_queue.size() == 0) begin
                    report("unexpected result", i_fib_mod, '0);
                end else begin
                    exp_r = fib_queue.pop_front();
                    if (i_fib_mod !== exp_r.fib) report("fib_mod", i_fib_mod, exp_r.fib);
                    if (i_doubled_fib_mod !== exp_r.dbl)
                        report("doubled_fib_mod", i_doubled_fib_mod, exp_r.dbl);
                end
            end
        end
        r_pending <= fib_queue.size();
    end
endmodule

>>> tb/tb_top.sv
// Testbench top for the Fibonacci modulo block: stimulus, watchdog and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 40000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] index_n = '0;
    logic [31:0] modulus = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] fib_mod;
    logic [31:0] doubled_fib_mod;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    always #2 clk = ~clk;

    fibonacci_fast_doubling_mod_top uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_index_n(index_n), .i_modulus(modulus), .o_out_valid(out_valid),
        .i_out_ready(out_ready), .o_fib_mod(fib_mod), .o_doubled_fib_mod(doubled_fib_mod)
    );

    ffdm_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_index_n(index_n), .i_modulus(modulus), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_fib_mod(fib_mod), .i_doubled_fib_mod(doubled_fib_mod),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: alternating runs of ready and stall
    always @(posedge clk) begin
        if ($urandom_range(0, 7) == 0) out_ready <= ~out_ready;
    end

    always @(posedge clk) begin
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // present a request and hold it until accepted; valid stays high for the next one
    task automatic send_request(logic [31:0] n, logic [31:0] m);
        in_valid <= 1'b1;
        index_n <= n;
        modulus <= m;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] rand_modulus();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2: return $urandom_range(2, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_index();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 100);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] dir_n[12] = '{0, 1, 2, 3, 10, 46, 47, 93, 32'h8000_0000,
                                   32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        logic [31:0] dir_m[6] = '{0, 1, 2, 32'hFFFF_FFFF, 32'h8000_0000, 1_000_000_007};
        int sent;
        int burst;
        int wait_cycles;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 12; i++) send_request(dir_n[i], dir_m[i % 6]);
        for (int i = 0; i < 6; i++) send_request(dir_n[11 - i], dir_m[i]);
        in_valid <= 1'b0;
        @(posedge clk);
        // hold until every result has drained
        while (pending != 0) @(posedge clk);
        sent = 0;
        while (sent < 700) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < 700; b++) begin
                send_request(rand_index(), rand_modulus());
                sent++;
            end
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        wait_cycles = 0;
        while (pending != 0) @(posedge clk);
        while (wait_cycles < 4000 && !out_valid) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end
endmodule

>>> fibonacci_fast_doubling_mod_top.f
sv/ffdm_pkg.sv
sv/ffdm_datapath.sv
sv/ffdm_dp.sv
sv/ffdm_ctrl.sv
sv/fibonacci_fast_doubling_mod_top.sv
tb/ffdm_checker.sv
tb/tb_top.sv
